// ===== src/gpr_pkg.sv =====
// ----------------------------------------------------------------------------
// gpr_pkg
// shared types and constants for the gray palette access port
// ----------------------------------------------------------------------------
`default_nettype none

package gpr_pkg;

    localparam int unsigned PAL_ENTRIES = 256;
    localparam int unsigned PAL_IDX_W   = 8;
    localparam int unsigned GRAY_W      = 8;
    localparam int unsigned CNT_W       = 5;

    // number of entries painted by one gray write
    localparam logic [CNT_W-1:0] COPIES_CNT = 5'd16;

    // a 16-byte step is 5 whole entries plus one byte
    localparam logic [PAL_IDX_W-1:0] STEP_IDX = 8'd5;

    // byte position inside an entry
    localparam logic [1:0] REM_RED   = 2'd0;
    localparam logic [1:0] REM_GREEN = 2'd1;
    localparam logic [1:0] REM_BLUE  = 2'd2;

    localparam logic [7:0] OFF_MAP_ADDR = 8'h00;
    localparam logic [7:0] OFF_MAP_DATA = 8'h04;
    localparam logic [7:0] OFF_CLEAR    = 8'h08;
    localparam logic [7:0] OFF_OVERLAY  = 8'h0C;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_BUSY,
        ST_RESULT
    } state_t;

    typedef struct packed
    {
        logic                 start;
        logic [PAL_IDX_W-1:0] idx;
        logic [GRAY_W-1:0]    gray;
    } gray_req_t;

    typedef struct packed
    {
        logic done;
        logic changed;
    } gray_rsp_t;

endpackage

`default_nettype wire

// ===== src/gray_palette_ramdac_regs.sv =====
// ----------------------------------------------------------------------------
// gray_palette_ramdac_regs
// byte-wide register port for a 16-level grayscale palette
// ----------------------------------------------------------------------------
// Each input transaction is one register access and yields one output
// transaction. Plain register reads and writes give a valid result in the
// cycle after accept. A map-data write on a green byte paints 16 palette
// entries through one registered-read memory port, one entry per cycle with
// read and write overlapped, and its result is valid once the last entry is
// written. The block takes one access at a time and is ready again after the
// result is taken. The palette reads as zero after reset through per-entry
// valid bits, with no clearing pass.
`default_nettype none

module gray_palette_ramdac_regs
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // reg_offset[7:0], write_data[15:8]
    input  wire logic        s_axis_tuser,  // op[0]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // read_data[7:0]
    output logic             m_axis_tuser   // redraw[0]
);

    gpr_pkg::state_t state_reg, state_next;

    logic [7:0] map_address_reg, map_address_next;
    logic [7:0] map_data_reg, map_data_next;
    logic [7:0] clear_reg, clear_next;
    logic [7:0] overlay_reg, overlay_next;
    logic [gpr_pkg::PAL_IDX_W-1:0] pidx_reg, pidx_next;
    logic [1:0] prem_reg, prem_next;
    logic [7:0] rd_reg, rd_next;
    logic       redraw_reg, redraw_next;
    logic       hi_reg, hi_next;

    logic       accept;
    logic       op;
    logic [7:0] reg_offset;
    logic [7:0] write_data;
    logic       gray_start;

    gpr_pkg::gray_req_t req;
    gpr_pkg::gray_rsp_t rsp;

    assign op         = s_axis_tuser;
    assign reg_offset = s_axis_tdata[7:0];
    assign write_data = s_axis_tdata[15:8];
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign gray_start = accept && (op == gpr_pkg::OP_WRITE) &&
                        (reg_offset == gpr_pkg::OFF_MAP_DATA) &&
                        (prem_reg == gpr_pkg::REM_GREEN);

    assign req.start = gray_start;
    assign req.idx   = pidx_reg;
    assign req.gray  = {write_data[3:0], 4'b0000} + write_data;

    gpr_palette u_palette
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gpr_pkg::ST_IDLE:
            begin
                if (gray_start)
                begin
                    state_next = gpr_pkg::ST_BUSY;
                end
                else if (accept)
                begin
                    state_next = gpr_pkg::ST_RESULT;
                end
            end
            gpr_pkg::ST_BUSY:
            begin
                if (rsp.done)
                begin
                    state_next = gpr_pkg::ST_RESULT;
                end
            end
            gpr_pkg::ST_RESULT:
            begin
                if (m_axis_tready)
                begin
                    state_next = gpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gpr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = (state_reg == gpr_pkg::ST_IDLE);
        m_axis_tvalid = (state_reg == gpr_pkg::ST_RESULT);
        m_axis_tdata  = rd_reg;
        m_axis_tuser  = redraw_reg;
    end

    // register file and offset tracking
    always_comb
    begin
        map_address_next = map_address_reg;
        map_data_next    = map_data_reg;
        clear_next       = clear_reg;
        overlay_next     = overlay_reg;
        pidx_next        = pidx_reg;
        prem_next        = prem_reg;
        rd_next          = rd_reg;
        redraw_next      = redraw_reg;
        hi_next          = hi_reg;

        if (accept)
        begin
            rd_next     = '0;
            redraw_next = 1'b0;
            hi_next     = |write_data[7:4];
            case (reg_offset)
                gpr_pkg::OFF_MAP_ADDR:
                begin
                    if (op == gpr_pkg::OP_WRITE)
                    begin
                        map_address_next = write_data;
                        pidx_next        = {4'b0000, write_data[3:0]};
                        prem_next        = gpr_pkg::REM_RED;
                    end
                    else
                    begin
                        rd_next = map_address_reg;
                    end
                end
                gpr_pkg::OFF_MAP_DATA:
                begin
                    if (op == gpr_pkg::OP_WRITE)
                    begin
                        map_data_next = write_data;
                        if (prem_reg == gpr_pkg::REM_BLUE)
                        begin
                            prem_next = gpr_pkg::REM_RED;
                            pidx_next = pidx_reg + 1'b1;
                        end
                        else
                        begin
                            prem_next = prem_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rd_next = map_data_reg;
                    end
                end
                gpr_pkg::OFF_CLEAR:
                begin
                    if (op == gpr_pkg::OP_WRITE)
                    begin
                        clear_next = write_data;
                    end
                    else
                    begin
                        rd_next = clear_reg;
                    end
                end
                gpr_pkg::OFF_OVERLAY:
                begin
                    if (op == gpr_pkg::OP_WRITE)
                    begin
                        overlay_next = write_data;
                    end
                    else
                    begin
                        rd_next = overlay_reg;
                    end
                end
                default:
                begin
                    rd_next = '0;
                end
            endcase
        end
        else if ((state_reg == gpr_pkg::ST_BUSY) && rsp.done)
        begin
            redraw_next = rsp.changed | hi_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= gpr_pkg::ST_IDLE;
            map_address_reg <= '0;
            map_data_reg    <= '0;
            clear_reg       <= '0;
            overlay_reg     <= '0;
            pidx_reg        <= '0;
            prem_reg        <= gpr_pkg::REM_RED;
        end
        else
        begin
            state_reg       <= state_next;
            map_address_reg <= map_address_next;
            map_data_reg    <= map_data_next;
            clear_reg       <= clear_next;
            overlay_reg     <= overlay_next;
            pidx_reg        <= pidx_next;
            prem_reg        <= prem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg     <= rd_next;
        redraw_reg <= redraw_next;
        hi_reg     <= hi_next;
    end

    // gray sequencer only finishes while an access is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> state_reg == gpr_pkg::ST_BUSY)
        else $error("gray sequencer done outside busy state");

    // byte position within an entry stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        prem_reg != 2'd3)
        else $error("palette byte position out of range");

    // a redraw only comes from a write, which returns zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == 8'h00)
        else $error("redraw with nonzero read data");

    // a gray write always moves the block into the busy state
    assert property (@(posedge clk) disable iff (!rst_n)
        gray_start |=> state_reg == gpr_pkg::ST_BUSY)
        else $error("gray write did not start the sequencer");

endmodule

`default_nettype wire

// ===== src/gpr_palette.sv =====
// ----------------------------------------------------------------------------
// gpr_palette
// palette store with a read-modify-write sequencer that paints gray entries
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_palette
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gpr_pkg::gray_req_t req,
    output gpr_pkg::gray_rsp_t      rsp
);

    logic [gpr_pkg::GRAY_W-1:0] mem [gpr_pkg::PAL_ENTRIES];
    logic [gpr_pkg::GRAY_W-1:0] rdata_reg;
    logic [gpr_pkg::PAL_ENTRIES-1:0] valid_reg, valid_next;

    logic                          active_reg, active_next;
    logic [gpr_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [gpr_pkg::PAL_IDX_W-1:0] ridx_reg, ridx_next;
    logic [1:0]                    rem_reg, rem_next;
    logic [gpr_pkg::PAL_IDX_W-1:0] widx_reg, widx_next;
    logic                          wpend_reg, wpend_next;
    logic [gpr_pkg::GRAY_W-1:0]    gray_reg, gray_next;
    logic                          changed_reg, changed_next;

    logic rd_en;
    logic entry_valid;
    logic hit_change;

    assign rd_en       = active_reg && (cnt_reg != gpr_pkg::COPIES_CNT);
    assign entry_valid = valid_reg[widx_reg];
    assign hit_change  = wpend_reg &&
                         (entry_valid ? (rdata_reg != gray_reg) : (gray_reg != '0));

    assign rsp.done    = active_reg && !rd_en && wpend_reg;
    assign rsp.changed = changed_reg | hit_change;

    always_comb
    begin
        active_next  = active_reg;
        cnt_next     = cnt_reg;
        ridx_next    = ridx_reg;
        rem_next     = rem_reg;
        widx_next    = widx_reg;
        wpend_next   = 1'b0;
        gray_next    = gray_reg;
        changed_next = changed_reg | hit_change;
        valid_next   = valid_reg;

        if (wpend_reg)
        begin
            valid_next[widx_reg] = 1'b1;
        end

        if (req.start)
        begin
            active_next  = 1'b1;
            cnt_next     = '0;
            ridx_next    = req.idx;
            rem_next     = gpr_pkg::REM_GREEN;
            gray_next    = req.gray;
            changed_next = 1'b0;
        end
        else if (rd_en)
        begin
            widx_next  = ridx_reg;
            wpend_next = 1'b1;
            cnt_next   = cnt_reg + 1'b1;
            if (rem_reg == gpr_pkg::REM_BLUE)
            begin
                ridx_next = ridx_reg + gpr_pkg::STEP_IDX + 1'b1;
                rem_next  = gpr_pkg::REM_RED;
            end
            else
            begin
                ridx_next = ridx_reg + gpr_pkg::STEP_IDX;
                rem_next  = rem_reg + 1'b1;
            end
        end
        else if (rsp.done)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            cnt_reg     <= '0;
            wpend_reg   <= 1'b0;
            changed_reg <= 1'b0;
            valid_reg   <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            cnt_reg     <= cnt_next;
            wpend_reg   <= wpend_next;
            changed_reg <= changed_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= ridx_next;
        rem_reg  <= rem_next;
        widx_reg <= widx_next;
        gray_reg <= gray_next;
    end

    // palette memory, registered read
    always_ff @(posedge clk)
    begin
        if (wpend_reg)
        begin
            mem[widx_reg] <= gray_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[ridx_reg];
        end
    end

endmodule

`default_nettype wire
